### rtl/core/ritoa_pkg.sv
// ----------------------------------------------------------------------------
// ritoa_pkg: shared constants and helpers for the radix integer to ascii block
// Register map codes, field widths, digit encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package ritoa_pkg;

	localparam int RADIX_W   = 6;
	localparam int DIGIT_W   = 6;
	localparam int CHAR_W    = 7;
	// remainder holds one extra bit for the shifted-in dividend bit
	localparam int REM_W     = RADIX_W + 1;
	// restoring division steps done in one clock
	localparam int DIV_STEPS = 4;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 3;
	localparam int REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_RADIX = 1'd0;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

	localparam logic [DIGIT_W-1:0] LAST_DEC_DIGIT = 6'd9;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO     = 7'd48;
	localparam logic [CHAR_W-1:0]  LETTER_OFFSET  = 7'd55;

	typedef struct packed {
		logic push;
		logic full;
	} front_q_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} back_q_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {1'b0, d};
		if (d <= LAST_DEC_DIGIT) begin
			return dx + ASCII_ZERO;
		end
		return dx + LETTER_OFFSET;
	endfunction

endpackage

`default_nettype wire

### rtl/core/ritoa_ram.sv
// ----------------------------------------------------------------------------
// ritoa_ram: generic single-port-write, single-port-read ram
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ritoa_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 31
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire                       re,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/ritoa_front.sv
// ----------------------------------------------------------------------------
// ritoa_front: configuration register and input classification
// Holds the radix register and tags each accepted value with its clamped radix.
// ----------------------------------------------------------------------------
`default_nettype none

module ritoa_front
	import ritoa_pkg::*;
#(
	parameter int VALUE_BITS = 31
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      psel,
	input  wire                      penable,
	input  wire                      pwrite,
	input  wire [APB_AW-1:0]         paddr,
	input  wire [APB_DW-1:0]         pwdata,
	output logic [APB_DW-1:0]        prdata,
	input  wire                      push,
	output logic                     full,
	input  wire [VALUE_BITS-1:0]     value,
	output front_q_t                 qctl,
	input  wire                      q_full,
	output logic [RADIX_W+VALUE_BITS-1:0] job
);

	logic [RADIX_W-1:0]   radix_q;
	logic [RADIX_W-1:0]   radix_eff;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign reg_idx = paddr[APB_AW-1 -: REG_IDX_W];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (wr_en && reg_idx == REG_RADIX) begin
			radix_q <= pwdata[RADIX_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_RADIX) begin
			prdata = {{(APB_DW-RADIX_W){1'b0}}, radix_q};
		end
	end

	// clamp the radix into 2..36
	always_comb begin
		priority if (radix_q < RADIX_MIN) begin
			radix_eff = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			radix_eff = RADIX_MAX;
		end else begin
			radix_eff = radix_q;
		end
	end

	assign full      = q_full;
	assign qctl.push = push && !q_full;
	assign qctl.full = q_full;
	assign job       = {radix_eff, value};

endmodule

`default_nettype wire

### rtl/core/ritoa_fifo.sv
// ----------------------------------------------------------------------------
// ritoa_fifo: two-entry job queue between front and back
// Decouples input acceptance from the conversion engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ritoa_fifo
	import ritoa_pkg::*;
#(
	parameter int WIDTH = 37
) (
	input  wire              clk,
	input  wire              arst_n,
	input  front_q_t         fctl,
	input  wire [WIDTH-1:0]  wdata,
	output logic             full,
	input  wire              pop,
	output back_q_t          bctl,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] ent_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       cnt_q;
	logic             do_pop;

	assign full       = cnt_q == 2'd2;
	assign do_pop     = pop && cnt_q != 2'd0;
	assign bctl.pop   = do_pop;
	assign bctl.empty = cnt_q == 2'd0;
	assign rdata      = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (fctl.push) begin
			ent_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (fctl.push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			unique case ({fctl.push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/ritoa_back.sv
// ----------------------------------------------------------------------------
// ritoa_back: iterative radix divider and digit emitter
// Splits a value into digits into the digit store, then replays them msd first.
// ----------------------------------------------------------------------------
`default_nettype none

module ritoa_back
	import ritoa_pkg::*;
#(
	parameter int VALUE_BITS = 31
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  back_q_t                       qstat,
	output logic                          q_pop,
	input  wire [RADIX_W+VALUE_BITS-1:0]  job,
	output logic                          empty,
	input  wire                           pop,
	output logic [CHAR_W-1:0]             character,
	output logic                          last
);

	localparam int ITERS  = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
	localparam int PAD    = ITERS * DIV_STEPS;
	localparam int IT_W   = $clog2(ITERS);
	localparam int CNT_W  = $clog2(VALUE_BITS + 1);
	localparam int ADDR_W = $clog2(VALUE_BITS);

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_DIV     = 4'b0010,
		ST_EMIT_RD = 4'b0100,
		ST_EMIT_WR = 4'b1000
	} state_t;

	state_t             state_q;
	logic [PAD-1:0]     quo_q;
	logic [REM_W-1:0]   rem_q;
	logic [RADIX_W-1:0] radix_q;
	logic [IT_W-1:0]    iter_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ADDR_W-1:0]  idx_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_last_q;

	logic [PAD-1:0]     quo_nx;
	logic [REM_W-1:0]   rem_nx;
	logic               digit_done;
	logic               ram_we;
	logic               ram_re;
	logic [DIGIT_W-1:0] ram_rdata;
	logic               out_free;

	// DIV_STEPS restoring steps on the narrow remainder
	always_comb begin
		quo_nx = quo_q;
		rem_nx = rem_q;
		for (int s = 0; s < DIV_STEPS; s++) begin
			rem_nx = {rem_nx[REM_W-2:0], quo_nx[PAD-1]};
			quo_nx = {quo_nx[PAD-2:0], 1'b0};
			if (rem_nx >= {1'b0, radix_q}) begin
				rem_nx    = rem_nx - {1'b0, radix_q};
				quo_nx[0] = 1'b1;
			end
		end
	end

	assign digit_done = (state_q == ST_DIV) && (iter_q == IT_W'(ITERS - 1));
	assign ram_we     = digit_done;
	assign ram_re     = state_q == ST_EMIT_RD;
	assign q_pop      = (state_q == ST_IDLE) && !qstat.empty;
	assign out_free   = !out_valid_q || pop;

	ritoa_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (VALUE_BITS)
	) u_digit_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (rem_nx[DIGIT_W-1:0]),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			radix_q <= RADIX_RESET;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						quo_q   <= {{(PAD-VALUE_BITS){1'b0}}, job[VALUE_BITS-1:0]};
						radix_q <= job[RADIX_W+VALUE_BITS-1 -: RADIX_W];
						rem_q   <= '0;
						iter_q  <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (digit_done) begin
						cnt_q  <= cnt_q + CNT_W'(1);
						iter_q <= '0;
						rem_q  <= '0;
						quo_q  <= quo_nx;
						if (quo_nx == '0 || cnt_q == CNT_W'(VALUE_BITS - 1)) begin
							idx_q   <= cnt_q[ADDR_W-1:0];
							state_q <= ST_EMIT_RD;
						end
					end else begin
						iter_q <= iter_q + IT_W'(1);
						quo_q  <= quo_nx;
						rem_q  <= rem_nx;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (out_free) begin
						if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q - ADDR_W'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register keeps a result while the engine moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT_WR && out_free) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_WR && out_free) begin
			out_char_q <= digit_to_ascii(ram_rdata);
			out_last_q <= idx_q == '0;
		end
	end

	assign empty     = !out_valid_q;
	assign character = out_char_q;
	assign last      = out_last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(VALUE_BITS))
		else $error("digit count beyond store depth");

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < {1'b0, radix_q})
		else $error("partial remainder not below radix");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_RD |-> {{(CNT_W-ADDR_W){1'b0}}, idx_q} < cnt_q)
		else $error("digit read outside converted digits");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == ST_DIV)
		else $error("job taken without starting division");

endmodule

`default_nettype wire

### rtl/core/radix_integer_to_ascii.sv
// The idle engine takes a job from the queue and the divider works out its digits lsd first
// into the digit store; each digit is then read back through the store read port (ST_EMIT_RD)
// and written to the output register (ST_EMIT_WR), msd first, with the readback held while a
// character waits in the output register to be popped
// reset: radix returns to 10, queue and output register empty; the digit store is not cleared
// ----------------------------------------------------------------------------
// radix_integer_to_ascii: integer to radix digit string converter
// Turns each value into ascii digits, msd first, flagging the final digit.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_integer_to_ascii
	import ritoa_pkg::*;
#(
	parameter int VALUE_BITS = 31
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   psel,
	input  wire                   penable,
	input  wire                   pwrite,
	input  wire [APB_AW-1:0]      paddr,
	input  wire [APB_DW-1:0]      pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready,
	input  wire                   push,
	output logic                  full,
	input  wire [VALUE_BITS-1:0]  value,
	output logic                  empty,
	input  wire                   pop,
	output logic [CHAR_W-1:0]     character,
	output logic                  last
);

	localparam int JOB_W = RADIX_W + VALUE_BITS;

	front_q_t         fctl;
	back_q_t          bctl;
	logic             q_full;
	logic             q_pop;
	logic [JOB_W-1:0] job_in;
	logic [JOB_W-1:0] job_out;

	assign pready = 1'b1;

	ritoa_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.push    (push),
		.full    (full),
		.value   (value),
		.qctl    (fctl),
		.q_full  (q_full),
		.job     (job_in)
	);

	ritoa_fifo #(
		.WIDTH (JOB_W)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.fctl   (fctl),
		.wdata  (job_in),
		.full   (q_full),
		.pop    (q_pop),
		.bctl   (bctl),
		.rdata  (job_out)
	);

	ritoa_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (bctl),
		.q_pop     (q_pop),
		.job       (job_out),
		.empty     (empty),
		.pop       (pop),
		.character (character),
		.last      (last)
	);

endmodule

`default_nettype wire

### sim/ritoa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ritoa_checker: digit stream predictor and scoreboard
// Follows the radix register over the config port, works out the ascii digits
// of every accepted value and compares each popped character against them.
// ----------------------------------------------------------------------------

module ritoa_checker
	import ritoa_pkg::*;
#(
	parameter int VALUE_BITS = 31
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   psel,
	input  wire                   penable,
	input  wire                   pwrite,
	input  wire [APB_AW-1:0]      paddr,
	input  wire [APB_DW-1:0]      pwdata,
	input  wire [APB_DW-1:0]      prdata,
	input  wire                   pready,
	input  wire                   push,
	input  wire                   full,
	input  wire [VALUE_BITS-1:0]  value,
	input  wire                   empty,
	input  wire                   pop,
	input  wire [CHAR_W-1:0]      character,
	input  wire                   last,
	output int                    failures,
	output int                    pending
);

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} digit_char_t;

	digit_char_t        expected_chars[$];
	logic [RADIX_W-1:0] radix_reg;

	// counts a failure, tells whether it still gets printed
	function automatic bit tally();
		failures++;
		return failures <= 10;
	endfunction

	// split a value into digits of the saturated radix, msd first
	task automatic predict_digits(input logic [VALUE_BITS-1:0] v);
		logic [VALUE_BITS-1:0] rest;
		logic [DIGIT_W-1:0]    digits[VALUE_BITS];
		logic [RADIX_W-1:0]    base;
		int                    n;
		digit_char_t           c;
		if (radix_reg < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix_reg > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = radix_reg;
		end
		rest = v;
		n = 0;
		do begin
			digits[n] = DIGIT_W'(rest % base);
			rest = rest / base;
			n++;
		end while (rest != 0 && n < VALUE_BITS);
		for (int k = n - 1; k >= 0; k--) begin
			if (digits[k] <= LAST_DEC_DIGIT) begin
				c.ch = CHAR_W'(digits[k]) + ASCII_ZERO;
			end else begin
				c.ch = CHAR_W'(digits[k]) + LETTER_OFFSET;
			end
			c.last = (k == 0);
			expected_chars.push_back(c);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		digit_char_t want;
		if (!arst_n) begin
			radix_reg = RADIX_RESET;
			expected_chars.delete();
		end else begin
			if (psel && penable && pready && paddr[APB_AW-1:2] == REG_RADIX) begin
				if (pwrite) begin
					radix_reg = pwdata[RADIX_W-1:0];
				end else if (prdata !== APB_DW'(radix_reg)) begin
					if (tally()) begin
						$display("%0t radix readback: expected %0d got %0h", $realtime,
							radix_reg, prdata);
					end
				end
			end
			if (push && !full) begin
				predict_digits(value);
			end
			if (pop && !empty) begin
				if (expected_chars.size() == 0) begin
					if (tally()) begin
						$display("%0t unexpected character %0d last %0b", $realtime,
							character, last);
					end
				end else begin
					want = expected_chars.pop_front();
					if (character !== want.ch || last !== want.last) begin
						if (tally()) begin
							$display("%0t character: expected %0d got %0d, last: expected %0b got %0b",
								$realtime, want.ch, character, want.last, last);
						end
					end
				end
			end
		end
		pending = expected_chars.size();
	end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: radix integer to ascii converter testbench
// Drives values and radix settings with random gaps on both queue sides and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------

module tb;
	import ritoa_pkg::*;

	localparam int                    VALUE_BITS    = 31;
	localparam logic [VALUE_BITS-1:0] VALUE_MAX     = '1;
	localparam int                    CYCLE_LIMIT   = 1_000_000;
	localparam int                    SETTLE_CYCLES = 40;
	localparam int                    PHASES        = 8;
	localparam int                    PHASE_ITEMS   = 36;
	localparam logic [APB_AW-1:0]     ADDR_RADIX    = APB_AW'(REG_RADIX) << 2;
	// first address past the register map, writes there must be dropped
	localparam logic [APB_AW-1:0]     ADDR_UNMAPPED = ADDR_RADIX + APB_AW'(4);

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_AW-1:0]     paddr;
	logic [APB_DW-1:0]     pwdata;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;
	logic                  push;
	logic                  full;
	logic [VALUE_BITS-1:0] value;
	logic                  empty;
	logic                  pop;
	logic [CHAR_W-1:0]     character;
	logic                  last;
	int                    failures;
	int                    pending;
	int                    cycles = 0;
	bit                    tx_burst = 1'b0;
	bit                    rx_burst = 1'b0;
	int                    pop_hold;

	radix_integer_to_ascii #(.VALUE_BITS(VALUE_BITS)) i_dut (.*);

	ritoa_checker #(.VALUE_BITS(VALUE_BITS)) i_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side: random stalls drawn per transaction, with burst stretches
	initial begin
		pop = 1'b0;
		pop_hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (pop_hold == 0) begin
				pop <= 1'b1;
			end else begin
				pop <= 1'b0;
				pop_hold--;
			end
			@(posedge clk);
			if (pop && !empty) begin
				if ($urandom_range(0, 15) == 0) begin
					rx_burst = !rx_burst;
				end
				pop_hold = rx_burst ? 0 : $urandom_range(0, 6);
			end
		end
	end

	task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
		input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// stop pushing and wait for every expected character to come out
	task automatic drain();
		push <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_radix(input logic [RADIX_W-1:0] r);
		drain();
		// random upper bits must not reach the radix
		apb_access(1'b1, ADDR_RADIX, APB_DW'({$urandom, r}));
		apb_access(1'b0, ADDR_RADIX, '0);
	endtask

	task automatic send_value(input logic [VALUE_BITS-1:0] v);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		value <= v;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	function automatic logic [VALUE_BITS-1:0] pick_value(input int base);
		longint p;
		int     k;
		case ($urandom_range(0, 7))
			0, 1, 2: return VALUE_BITS'($urandom);
			3: return VALUE_BITS'($urandom_range(0, base * base));
			// powers of the radix and one below, where the digit count steps
			4: begin
				p = 1;
				k = $urandom_range(1, 31);
				while (k > 0 && p * base <= longint'(VALUE_MAX)) begin
					p = p * base;
					k--;
				end
				return VALUE_BITS'(p - $urandom_range(0, 1));
			end
			5: return $urandom_range(0, 1) ? VALUE_MAX : '0;
			default: return VALUE_BITS'($urandom >> $urandom_range(1, 31));
		endcase
	endfunction

	initial begin
		logic [RADIX_W-1:0] r;
		int                 base;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		push = 1'b0;
		value = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// decimal out of reset
		send_value('0);
		send_value(VALUE_BITS'(9));
		send_value(VALUE_BITS'(10));
		send_value(VALUE_MAX);
		set_radix(6'd36);
		send_value(VALUE_BITS'(35));
		send_value(VALUE_BITS'(36));
		send_value(VALUE_BITS'(1295));
		set_radix(6'd2);
		send_value(VALUE_MAX);
		send_value(VALUE_BITS'(1) << 30);
		send_value(VALUE_BITS'(1));
		// radix below two saturates to binary
		set_radix(6'd0);
		send_value(VALUE_BITS'(5));
		set_radix(6'd1);
		send_value(VALUE_BITS'(6));
		// radix above thirty-six saturates to 36
		set_radix(6'd37);
		send_value(VALUE_BITS'(1295));
		set_radix(6'd63);
		send_value(VALUE_MAX);
		// unmapped write leaves the radix alone
		drain();
		apb_access(1'b1, ADDR_UNMAPPED, APB_DW'(2));
		send_value(VALUE_BITS'(100));
		set_radix(6'd16);
		send_value(31'h2AAA_AAAA);
		send_value(31'h1555_5555);
		send_value(VALUE_MAX);
		set_radix(6'd8);
		send_value(VALUE_MAX);
		send_value('0);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: r = 6'd2;
				1: r = 6'd36;
				2: r = 6'd10;
				3: r = 6'd16;
				4: r = 6'd7;
				default: r = RADIX_W'($urandom_range(0, 63));
			endcase
			set_radix(r);
			base = r < RADIX_MIN ? RADIX_MIN : (r > RADIX_MAX ? RADIX_MAX : r);
			tx_burst = (phase % 3 == 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// sender holds off until everything is out
				if (phase == 4 && i == PHASE_ITEMS / 2) begin
					drain();
				end
				send_value(pick_value(base));
			end
		end

		drain();
		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
